// File: hw/rtl/iau_pkg.sv
// ----------------------------------------------------------------------------
// Interval arithmetic unit package
// Shared payload types, operation codes, status codes and control bundles.
// ----------------------------------------------------------------------------
package iau_pkg;

    // Longest step run that is emitted
    localparam int MAX_RUN = 64;
    localparam int CNT_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    // Width for exact run bound arithmetic: 32-bit value plus scaled step
    localparam int RUN_W   = 34 + CNT_W + 1;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_NEG = 3'd4,
        FN_EQ  = 3'd5,
        FN_NE  = 3'd6,
        FN_RUN = 3'd7
    } func_t;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DIVZ  = 3'd1;
    localparam logic [2:0] ST_BADST = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] a_lower;
        logic signed [31:0] a_upper;
        logic signed [31:0] b_lower;
        logic signed [31:0] b_upper;
        logic signed [31:0] step;
    } in_t;

    typedef struct packed {
        logic signed [31:0] res_lower;
        logic signed [31:0] res_upper;
        logic               compare_flag;
        logic signed [31:0] run_value;
        logic [2:0]         status;
        logic               last;
    } out_t;

    // Kind of result loaded into the output register
    typedef enum logic [2:0] {
        OK_ARITH,
        OK_MINMAX,
        OK_DIVZ,
        OK_BADSTEP,
        OK_EMPTY,
        OK_RUN
    } out_kind_t;

    typedef struct packed {
        logic      load;
        logic      mul;
        logic      div_start;
        logic      fold;
        logic      fold_first;
        logic      fold_div;
        logic      run_init;
        logic      run_adv;
        logic      out_load;
        out_kind_t out_kind;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  div_zero;
        logic  step_bad;
        logic  run_empty;
        logic  run_last;
        logic  div_done;
        logic  out_free;
    } sts_t;

endpackage

// File: hw/rtl/interval_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Interval arithmetic unit
// Signed 32-bit interval add, subtract, multiply, divide, negate, compare
// and stepped run generation.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request: a function code, two intervals
//   and a step. m_valid/m_ready/m_data return results; every request gives
//   one result, except a step run, which gives one result per element (up
//   to MAX_RUN), with last set on the final one.
//   Add, subtract, negate and the compares are loaded from the operand
//   register; multiply folds four endpoint products (one 32x32 product per
//   cycle), divide folds four quotients through one radix-2 divider in
//   turn, and a step run gives one element per cycle while m_ready is high.
//   One request is in flight at a time; the next is taken once the last
//   result of the current one is in the output register, even while that
//   result waits for m_ready.
//   A stalled receiver holds the sequencer before each output load.
//   Reset (aresetn low, synchronous) drops any request in flight and
//   clears m_valid.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iau_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output iau_pkg::out_t m_data
);

    iau_pkg::cmd_t cmd;
    iau_pkg::sts_t sts;

    iau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    iau_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output overwritten before taken");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.out_load && !cmd.div_start && !cmd.run_adv)
        else $error("datapath active while idle");
`endif

endmodule

// File: hw/rtl/iau_div.sv
// ----------------------------------------------------------------------------
// Interval arithmetic unit divider
// Radix-2 restoring signed divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iau_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_sh;
    logic        ge;

    // Shift in next dividend bit and trial subtract
    assign rem_sh = {rem_reg, q_reg[31]};
    assign ge     = (rem_sh >= {1'b0, d_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 32'd0;
            q_next    = dividend[31] ? 32'(-dividend) : 32'(dividend);
            d_next    = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next  = dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            rem_next = ge ? 32'(rem_sh - {1'b0, d_reg}) : rem_sh[31:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(32'(-q_reg)) : $signed(q_reg);

endmodule

// File: hw/rtl/iau_dp.sv
// ----------------------------------------------------------------------------
// Interval arithmetic unit datapath
// Operand register, multiplier, divider, min/max fold, run stepper, output.
// ----------------------------------------------------------------------------
module iau_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  iau_pkg::in_t    s_data,
    input  iau_pkg::cmd_t   cmd,
    output iau_pkg::sts_t   sts,
    output logic            m_valid,
    input  logic            m_ready,
    output iau_pkg::out_t   m_data
);

    iau_pkg::in_t  in_reg, in_next;
    iau_pkg::out_t out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic signed [31:0] prod_reg, prod_next;
    logic signed [31:0] mn_reg, mn_next, mx_reg, mx_next;
    logic signed [iau_pkg::RUN_W-1:0] cur_reg, cur_next;
    logic [iau_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             trunc_reg, trunc_next;

    logic signed [31:0] op_x, op_y, fold_val, quo;
    logic signed [63:0] prod_full;
    logic signed [iau_pkg::RUN_W-1:0] a_w, b_w, s_w, cur_step, bound;
    logic               div_done;

    // Endpoint pair: index bit 1 picks the a endpoint, bit 0 the b endpoint (set = upper)
    assign op_x = cmd.idx[1] ? in_reg.a_upper : in_reg.a_lower;
    assign op_y = cmd.idx[0] ? in_reg.b_upper : in_reg.b_lower;
    assign prod_full = op_x * op_y;

    iau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (op_x),
        .divisor  (op_y),
        .done     (div_done),
        .quotient (quo)
    );

    // Wide run arithmetic
    assign a_w      = iau_pkg::RUN_W'(in_reg.a_lower);
    assign b_w      = iau_pkg::RUN_W'(in_reg.a_upper);
    assign s_w      = iau_pkg::RUN_W'(in_reg.step);
    assign cur_step = cur_reg + s_w;
    assign bound    = a_w + s_w * iau_pkg::RUN_W'(iau_pkg::MAX_RUN);

    assign fold_val = cmd.fold_div ? quo : prod_reg;

    always_comb begin
        in_next      = in_reg;
        prod_next    = prod_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        trunc_next   = trunc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (cmd.load) in_next = s_data;
        if (cmd.mul)  prod_next = prod_full[31:0];

        // Running min and max of endpoint results
        if (cmd.fold) begin
            if (cmd.fold_first) begin
                mn_next = fold_val;
                mx_next = fold_val;
            end else begin
                mn_next = (fold_val < mn_reg) ? fold_val : mn_reg;
                mx_next = (fold_val > mx_reg) ? fold_val : mx_reg;
            end
        end

        if (cmd.run_init) begin
            cur_next   = a_w;
            cnt_next   = '0;
            trunc_next = (bound <= b_w);
        end else if (cmd.run_adv) begin
            cur_next = cur_step;
            cnt_next = cnt_reg + iau_pkg::CNT_W'(1);
        end

        // Output register
        if (m_ready) m_valid_next = 1'b0;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            out_next     = '0;
            out_next.last = 1'b1;
            unique case (cmd.out_kind)
                iau_pkg::OK_ARITH: begin
                    unique case (in_reg.func)
                        iau_pkg::FN_ADD: begin
                            out_next.res_lower = in_reg.a_lower + in_reg.b_lower;
                            out_next.res_upper = in_reg.a_upper + in_reg.b_upper;
                        end
                        iau_pkg::FN_SUB: begin
                            out_next.res_lower = in_reg.a_lower - in_reg.b_upper;
                            out_next.res_upper = in_reg.a_upper - in_reg.b_lower;
                        end
                        iau_pkg::FN_NEG: begin
                            out_next.res_lower = -in_reg.a_upper;
                            out_next.res_upper = -in_reg.a_lower;
                        end
                        iau_pkg::FN_EQ:
                            out_next.compare_flag = (in_reg.a_lower == in_reg.b_lower) &&
                                                    (in_reg.a_upper == in_reg.b_upper);
                        iau_pkg::FN_NE:
                            out_next.compare_flag = !((in_reg.a_lower == in_reg.b_lower) &&
                                                      (in_reg.a_upper == in_reg.b_upper));
                        default: ;
                    endcase
                end
                iau_pkg::OK_MINMAX: begin
                    out_next.res_lower = mn_reg;
                    out_next.res_upper = mx_reg;
                end
                iau_pkg::OK_DIVZ:    out_next.status = iau_pkg::ST_DIVZ;
                iau_pkg::OK_BADSTEP: out_next.status = iau_pkg::ST_BADST;
                iau_pkg::OK_EMPTY:   out_next.status = iau_pkg::ST_EMPTY;
                iau_pkg::OK_RUN: begin
                    out_next.run_value = cur_reg[31:0];
                    out_next.status    = trunc_reg ? iau_pkg::ST_TRUNC : iau_pkg::ST_OK;
                    out_next.last      = sts.run_last;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        in_reg    <= in_next;
        out_reg   <= out_next;
        prod_reg  <= prod_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        trunc_reg <= trunc_next;
    end

    // Status toward the controller
    assign sts.func      = in_reg.func;
    assign sts.div_zero  = (in_reg.b_lower == 32'sd0) || (in_reg.b_upper == 32'sd0);
    assign sts.step_bad  = (in_reg.step < 32'sd1);
    assign sts.run_empty = (in_reg.a_upper < in_reg.a_lower);
    assign sts.run_last  = (cnt_reg == iau_pkg::CNT_W'(iau_pkg::MAX_RUN - 1)) ||
                           (cur_step > b_w);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == iau_pkg::ST_DIVZ |->
            m_data.res_lower == 32'sd0 && m_data.res_upper == 32'sd0 && m_data.last)
        else $error("divide by zero result not cleared");
    a_run_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.run_value != 32'sd0 |->
            m_data.res_lower == 32'sd0 && m_data.res_upper == 32'sd0 && !m_data.compare_flag)
        else $error("run element carries interval fields");
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && cmd.out_kind == iau_pkg::OK_RUN |-> cur_reg <= b_w)
        else $error("run element beyond upper bound");
`endif

endmodule

// File: hw/rtl/iau_ctrl.sv
// ----------------------------------------------------------------------------
// Interval arithmetic unit controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
module iau_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iau_pkg::sts_t sts,
    output iau_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_MUL,
        S_DIVW,
        S_FIN,
        S_RUN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.out_kind = iau_pkg::OK_ARITH;
        cmd.idx    = idx_reg[1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.func)
                    iau_pkg::FN_MUL: begin
                        idx_next   = 3'd0;
                        state_next = S_MUL;
                    end
                    iau_pkg::FN_DIV: begin
                        if (sts.div_zero) begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = iau_pkg::OK_DIVZ;
                                state_next   = S_IDLE;
                            end
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.idx       = 2'd0;
                            idx_next      = 3'd0;
                            state_next    = S_DIVW;
                        end
                    end
                    iau_pkg::FN_RUN: begin
                        if (sts.step_bad || sts.run_empty) begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = sts.step_bad ? iau_pkg::OK_BADSTEP
                                                            : iau_pkg::OK_EMPTY;
                                state_next   = S_IDLE;
                            end
                        end else begin
                            cmd.run_init = 1'b1;
                            state_next   = S_RUN;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = iau_pkg::OK_ARITH;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            // One product per cycle, folded the cycle after
            S_MUL: begin
                cmd.mul        = (idx_reg != 3'd4);
                cmd.fold       = (idx_reg != 3'd0);
                cmd.fold_first = (idx_reg == 3'd1);
                idx_next       = idx_reg + 3'd1;
                if (idx_reg == 3'd4) state_next = S_FIN;
            end
            // Fold each quotient and start the next one; after the fourth go to S_FIN
            S_DIVW: begin
                if (sts.div_done) begin
                    cmd.fold       = 1'b1;
                    cmd.fold_div   = 1'b1;
                    cmd.fold_first = (idx_reg == 3'd0);
                    if (idx_reg == 3'd3) begin
                        state_next = S_FIN;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.idx       = idx_reg[1:0] + 2'd1;
                        idx_next      = idx_reg + 3'd1;
                    end
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = iau_pkg::OK_MINMAX;
                    state_next   = S_IDLE;
                end
            end
            S_RUN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = iau_pkg::OK_RUN;
                    cmd.run_adv  = 1'b1;
                    if (sts.run_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
